>>> hdl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and constants of the configuration line tokenizer: byte
// classes, event codes, character codes, default widths and queue depth.
// ----------------------------------------------------------------------------
package clt_pkg;

  // default widths of the position and line counters
  localparam int unsigned POS_WIDTH_DEF  = 24;
  localparam int unsigned LINE_WIDTH_DEF = 20;

  // queue between classifier and execution part
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // character codes
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CH_DOT        = 8'h2e;
  localparam logic [7:0] CH_SLASH      = 8'h2f;
  localparam logic [7:0] CH_LBRACE     = 8'h7b;
  localparam logic [7:0] CH_RBRACE     = 8'h7d;
  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_SEMI       = 8'h3b;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0a;
  localparam logic [7:0] CH_CR         = 8'h0d;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7a;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5a;
  localparam logic [7:0] CH_DIGIT_0    = 8'h30;
  localparam logic [7:0] CH_DIGIT_9    = 8'h39;

  // byte classes produced by the front part
  typedef enum logic [3:0] {
    CLS_WORD,
    CLS_EOL,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_HASH,
    CLS_SEMI,
    CLS_BLANK,
    CLS_OTHER,
    CLS_END
  } cls_e;

  // result event codes
  typedef enum logic [2:0] {
    EVT_WORD  = 3'd0,
    EVT_OK    = 3'd1,
    EVT_OPEN  = 3'd2,
    EVT_CLOSE = 3'd3,
    EVT_ERROR = 3'd4,
    EVT_END   = 3'd5
  } evt_e;

endpackage

>>> hdl/clt_front.sv
// ----------------------------------------------------------------------------
// clt_front
// Byte classifier: maps an incoming text byte or end mark to its class.
// ----------------------------------------------------------------------------
module clt_front (
  input  logic          [7:0] text_byte_i,
  input  logic                end_of_input_i,
  output clt_pkg::cls_e       cls_o
);

  // classify the byte, end mark first
  always_comb begin
    if (end_of_input_i) begin
      cls_o = clt_pkg::CLS_END;
    end else if (text_byte_i inside {[clt_pkg::CH_LOWER_A:clt_pkg::CH_LOWER_Z],
                                     [clt_pkg::CH_UPPER_A:clt_pkg::CH_UPPER_Z],
                                     [clt_pkg::CH_DIGIT_0:clt_pkg::CH_DIGIT_9],
                                     clt_pkg::CH_UNDERSCORE, clt_pkg::CH_DOT,
                                     clt_pkg::CH_SLASH}) begin
      cls_o = clt_pkg::CLS_WORD;
    end else if (text_byte_i inside {clt_pkg::CH_LF, clt_pkg::CH_CR}) begin
      cls_o = clt_pkg::CLS_EOL;
    end else if (text_byte_i inside {clt_pkg::CH_SPACE, clt_pkg::CH_TAB}) begin
      cls_o = clt_pkg::CLS_BLANK;
    end else begin
      case (text_byte_i)
        clt_pkg::CH_LBRACE: cls_o = clt_pkg::CLS_OPEN;
        clt_pkg::CH_RBRACE: cls_o = clt_pkg::CLS_CLOSE;
        clt_pkg::CH_HASH:   cls_o = clt_pkg::CLS_HASH;
        clt_pkg::CH_SEMI:   cls_o = clt_pkg::CLS_SEMI;
        default:            cls_o = clt_pkg::CLS_OTHER;
      endcase
    end
  end

endmodule

>>> hdl/clt_queue.sv
// ----------------------------------------------------------------------------
// clt_queue
// Short FIFO of byte classes between the classifier and the execution part.
// ----------------------------------------------------------------------------
module clt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_stall_o,
  input  clt_pkg::cls_e wr_cls_i,
  output logic          rd_valid_o,
  input  logic          rd_take_i,
  output clt_pkg::cls_e rd_cls_o
);

  clt_pkg::cls_e                      mem_q [clt_pkg::QUEUE_DEPTH];
  logic [clt_pkg::QUEUE_AW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [clt_pkg::QUEUE_AW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [clt_pkg::QUEUE_CW-1:0]       count_q, count_d;
  logic                               push, pop;

  assign wr_stall_o = (count_q == clt_pkg::QUEUE_CW'(clt_pkg::QUEUE_DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_cls_o   = mem_q[rd_ptr_q];

  assign push = wr_valid_i && !wr_stall_o;
  assign pop  = rd_take_i && rd_valid_o;

  // pointer and fill count
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_cls_i;
    end
  end

endmodule

>>> hdl/clt_back.sv
// ----------------------------------------------------------------------------
// clt_back
// Execution part: keeps position, line count and statement flags, and
// registers a result word for each taken class that closes a word or gives an event.
// ----------------------------------------------------------------------------
module clt_back #(
  parameter int unsigned POS_WIDTH  = clt_pkg::POS_WIDTH_DEF,
  parameter int unsigned LINE_WIDTH = clt_pkg::LINE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  clt_pkg::cls_e         q_cls_i,
  output logic                  q_take_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            event_kind_o,
  output logic [1:0]            word_index_o,
  output logic [POS_WIDTH-1:0]  word_start_o,
  output logic [POS_WIDTH-1:0]  word_end_o,
  output logic [LINE_WIDTH-1:0] line_number_o
);

  localparam logic [LINE_WIDTH-1:0] LINE_ONE = LINE_WIDTH'(1);

  // tokenizer state
  logic [POS_WIDTH-1:0]  pos_q, pos_d;
  logic [LINE_WIDTH-1:0] line_q, line_d;
  logic [1:0]            words_q, words_d;
  logic                  in_word_q, in_word_d;
  logic                  semi_q, semi_d;
  logic                  comment_q, comment_d;
  logic [POS_WIDTH-1:0]  first_q, first_d;
  logic [POS_WIDTH-1:0]  last_q, last_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  clt_pkg::evt_e         kind_q, kind_d;
  logic [1:0]            index_q, index_d;
  logic [POS_WIDTH-1:0]  start_q, start_d;
  logic [POS_WIDTH-1:0]  end_q, end_d;
  logic [LINE_WIDTH-1:0] lnum_q;

  logic                  emit_evt;
  logic                  emit_word;
  clt_pkg::evt_e         evt_kind;

  // take a class whenever the output slot is free or being emptied
  assign q_take_o = q_valid_i && (!out_valid_q || !out_stall_i);

  // per-class state update
  always_comb begin
    pos_d     = pos_q;
    line_d    = line_q;
    words_d   = words_q;
    in_word_d = in_word_q;
    semi_d    = semi_q;
    comment_d = comment_q;
    first_d   = first_q;
    last_d    = last_q;
    emit_evt  = 1'b0;
    emit_word = 1'b0;
    evt_kind  = clt_pkg::EVT_ERROR;

    if (q_cls_i == clt_pkg::CLS_END) begin
      emit_evt = 1'b1;
      evt_kind = clt_pkg::EVT_END;
    end else begin
      pos_d = pos_q + 1'b1;
      if (q_cls_i == clt_pkg::CLS_EOL) begin
        // line end, also closes a comment
        comment_d = 1'b0;
        line_d    = (line_q == '1) ? line_q : line_q + 1'b1;
        if (words_q == 2'd2 || semi_q) begin
          emit_evt = 1'b1;
          evt_kind = clt_pkg::EVT_OK;
        end else if (in_word_q) begin
          emit_evt = 1'b1;
          evt_kind = clt_pkg::EVT_ERROR;
        end
      end else if (!comment_q) begin
        case (q_cls_i)
          clt_pkg::CLS_WORD: begin
            if (!in_word_q) begin
              in_word_d = 1'b1;
              first_d   = pos_q;
            end
            last_d = pos_q;
          end
          clt_pkg::CLS_OPEN: begin
            emit_evt = 1'b1;
            evt_kind = clt_pkg::EVT_OPEN;
          end
          clt_pkg::CLS_CLOSE: begin
            emit_evt = 1'b1;
            evt_kind = clt_pkg::EVT_CLOSE;
          end
          clt_pkg::CLS_HASH: begin
            comment_d = 1'b1;
          end
          clt_pkg::CLS_SEMI: begin
            semi_d = 1'b1;
            if (words_q == 2'd2) begin
              emit_evt = 1'b1;
              evt_kind = clt_pkg::EVT_OK;
            end else if (in_word_q) begin
              emit_word = 1'b1;
            end
          end
          clt_pkg::CLS_BLANK: begin
            if (!semi_q && in_word_q) begin
              emit_word = 1'b1;
            end
          end
          default: begin
            emit_evt = 1'b1;
            evt_kind = clt_pkg::EVT_ERROR;
          end
        endcase
      end
    end

    // word closed: bump the saturating word count
    if (emit_word) begin
      words_d   = (words_q == 2'd3) ? words_q : words_q + 2'd1;
      in_word_d = 1'b0;
    end

    // non-word result clears the statement flags
    if (emit_evt) begin
      words_d   = '0;
      in_word_d = 1'b0;
      semi_d    = 1'b0;
      comment_d = 1'b0;
      first_d   = '0;
      last_d    = '0;
    end
  end

  // result word contents
  always_comb begin
    if (emit_word) begin
      kind_d  = clt_pkg::EVT_WORD;
      index_d = words_q;
      start_d = first_q;
      end_d   = last_q;
    end else begin
      kind_d  = evt_kind;
      index_d = '0;
      start_d = '0;
      end_d   = '0;
    end
  end

  // output slot occupancy
  always_comb begin
    if (q_take_o) begin
      out_valid_d = emit_evt || emit_word;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      line_q      <= LINE_ONE;
      words_q     <= '0;
      in_word_q   <= 1'b0;
      semi_q      <= 1'b0;
      comment_q   <= 1'b0;
      first_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (q_take_o) begin
        pos_q     <= pos_d;
        line_q    <= line_d;
        words_q   <= words_d;
        in_word_q <= in_word_d;
        semi_q    <= semi_d;
        comment_q <= comment_d;
        first_q   <= first_d;
        last_q    <= last_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (q_take_o && (emit_evt || emit_word)) begin
      kind_q  <= kind_d;
      index_q <= index_d;
      start_q <= start_d;
      end_q   <= end_d;
      lnum_q  <= line_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = kind_q;
  assign word_index_o  = index_q;
  assign word_start_o  = start_q;
  assign word_end_o    = end_q;
  assign line_number_o = lnum_q;

endmodule

>>> hdl/config_line_tokenizer_unit.sv
// An accepted byte's class is queued; any result word is registered when it is taken.
// Throughput: one byte per cycle; the execution part updates its state and the
// output register together as it takes a class, so only output stall slows the stream.
// A two-entry class queue holds up to two classes while the output is held.
// Reset (rst_ni low, asynchronous): position 0, line 1, flags clear, queue empty.
// ----------------------------------------------------------------------------
// config_line_tokenizer_unit
// Byte-serial tokenizer for line-oriented configuration text: classifier,
// class queue and execution part with a registered result word.
// ----------------------------------------------------------------------------
module config_line_tokenizer_unit #(
  parameter int unsigned POS_WIDTH  = clt_pkg::POS_WIDTH_DEF,
  parameter int unsigned LINE_WIDTH = clt_pkg::LINE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            text_byte_i,
  input  logic                  end_of_input_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            event_kind_o,
  output logic [1:0]            word_index_o,
  output logic [POS_WIDTH-1:0]  word_start_o,
  output logic [POS_WIDTH-1:0]  word_end_o,
  output logic [LINE_WIDTH-1:0] line_number_o
);

  clt_pkg::cls_e in_cls;
  clt_pkg::cls_e q_cls;
  logic          q_valid;
  logic          q_take;

  // classify incoming byte
  clt_front u_front (
    .text_byte_i    (text_byte_i),
    .end_of_input_i (end_of_input_i),
    .cls_o          (in_cls)
  );

  // decoupling queue
  clt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (in_valid_i),
    .wr_stall_o (in_stall_o),
    .wr_cls_i   (in_cls),
    .rd_valid_o (q_valid),
    .rd_take_i  (q_take),
    .rd_cls_o   (q_cls)
  );

  // tokenizer state and result register
  clt_back #(
    .POS_WIDTH  (POS_WIDTH),
    .LINE_WIDTH (LINE_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cls_i       (q_cls),
    .q_take_o      (q_take),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_kind_o  (event_kind_o),
    .word_index_o  (word_index_o),
    .word_start_o  (word_start_o),
    .word_end_o    (word_end_o),
    .line_number_o (line_number_o)
  );

endmodule
